// ===== sv/lpmd_pkg.sv =====
// Package for the length-prefixed message deframer.
// Holds header geometry constants and the result item type.
// No dependencies.
package lpmd_pkg;

	localparam int unsigned HDR_BYTES  = 8;
	localparam int unsigned WORD_BYTES = 4;
	localparam int unsigned HDR_CNT_W  = $clog2(HDR_BYTES);
	localparam int unsigned LANE_W     = $clog2(WORD_BYTES);

	localparam logic [HDR_CNT_W-1:0] HDR_LAST_CNT = HDR_CNT_W'(HDR_BYTES - 1);
	localparam logic [31:0]          ID_RESET     = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [31:0] message_id;
		logic [31:0] body_length;
		logic [7:0]  body_byte;
		logic        byte_valid;
		logic        last_of_message;
	} msg_item_t;

	typedef struct packed {
		logic      push;
		msg_item_t item;
	} msg_push_t;

endpackage

// ===== sv/lpmd_if.sv =====
// Valid/ready channel interfaces for the deframer: raw byte input and
// tagged result output. Depends on nothing.
interface lpmd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink   (input valid, input stream_byte, output ready);
endinterface

interface lpmd_msg_if;
	logic        valid;
	logic        ready;
	logic [31:0] message_id;
	logic [31:0] body_length;
	logic [7:0]  body_byte;
	logic        byte_valid;
	logic        last_of_message;

	modport source (output valid, output message_id, output body_length, output body_byte,
		output byte_valid, output last_of_message, input ready);
	modport sink   (input valid, input message_id, input body_length, input body_byte,
		input byte_valid, input last_of_message, output ready);
endinterface

// ===== sv/lpmd_tracker.sv =====
// Header collection and body counting for the deframer.
// Holds the message state registers; depends on lpmd_pkg.
module lpmd_tracker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         stream_byte,
	output lpmd_pkg::msg_push_t res
);
	import lpmd_pkg::*;

	logic                 in_body_q;
	logic [HDR_CNT_W-1:0] hdr_cnt_q;
	logic [31:0]          id_q;
	logic [31:0]          len_q;
	logic [31:0]          left_q;

	logic                 in_body_d;
	logic [HDR_CNT_W-1:0] hdr_cnt_d;
	logic [31:0]          id_d;
	logic [31:0]          len_d;
	logic [31:0]          left_d;
	logic                 last_body;
	logic [LANE_W-1:0]    lane;

	assign last_body = (left_q <= 32'd1);
	assign lane      = hdr_cnt_q[LANE_W-1:0];

	always_comb begin
		in_body_d = in_body_q;
		hdr_cnt_d = hdr_cnt_q;
		id_d      = id_q;
		len_d     = len_q;
		left_d    = left_q;
		res       = '0;
		if (in_body_q) begin
			res.push                 = 1'b1;
			res.item.message_id      = id_q;
			res.item.body_length     = len_q;
			res.item.body_byte       = stream_byte;
			res.item.byte_valid      = 1'b1;
			res.item.last_of_message = last_body;
			if (last_body) begin
				left_d    = '0;
				in_body_d = 1'b0;
				hdr_cnt_d = '0;
			end else begin
				left_d = left_q - 32'd1;
			end
		end else begin
			// low half of the header fills the id, high half the length
			if (!hdr_cnt_q[HDR_CNT_W-1])
				id_d[lane*8 +: 8] = stream_byte;
			else
				len_d[lane*8 +: 8] = stream_byte;
			if (hdr_cnt_q == HDR_LAST_CNT) begin
				hdr_cnt_d = '0;
				if (len_d == 32'd0) begin
					// empty body: one marker item, stay in header collection
					res.push                 = 1'b1;
					res.item.message_id      = id_d;
					res.item.body_length     = len_d;
					res.item.body_byte       = 8'd0;
					res.item.byte_valid      = 1'b0;
					res.item.last_of_message = 1'b1;
				end else begin
					left_d    = len_d;
					in_body_d = 1'b1;
				end
			end else begin
				hdr_cnt_d = hdr_cnt_q + 1'b1;
			end
		end
		if (!accept)
			res.push = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q <= 1'b0;
			hdr_cnt_q <= '0;
			id_q      <= ID_RESET;
			len_q     <= '0;
			left_q    <= '0;
		end else if (accept) begin
			in_body_q <= in_body_d;
			hdr_cnt_q <= hdr_cnt_d;
			id_q      <= id_d;
			len_q     <= len_d;
			left_q    <= left_d;
		end
	end

endmodule

// ===== sv/lpmd_out_stage.sv =====
// Two-entry output register for deframer result items: a main register
// and a skid register, so input ready never depends combinationally on the receiver.
// Depends on lpmd_pkg.
module lpmd_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  lpmd_pkg::msg_push_t res,
	output logic                space,
	output logic                out_valid,
	input  logic                out_ready,
	output lpmd_pkg::msg_item_t out_item
);
	import lpmd_pkg::*;

	logic      main_valid_q;
	logic      skid_valid_q;
	msg_item_t main_q;
	msg_item_t skid_q;
	logic      pop;

	assign pop       = main_valid_q && out_ready;
	assign space     = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_item  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				// no push possible while the skid entry is full
				if (pop)
					skid_valid_q <= 1'b0;
			end else if (!main_valid_q) begin
				main_valid_q <= res.push;
			end else if (pop) begin
				main_valid_q <= res.push;
			end else if (res.push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				main_q <= skid_q;
		end else if (!main_valid_q || pop) begin
			if (res.push)
				main_q <= res.item;
		end else if (res.push) begin
			skid_q <= res.item;
		end
	end

endmodule

// ===== sv/length_prefixed_message_deframer.sv =====
// Length-prefixed message deframer.
// Usage: raw bytes enter on the stream channel, one item per byte. Each
// message is an 8-byte header (32-bit id, then 32-bit body length, both
// least significant byte first) followed by that many body bytes.
// Header bytes produce no output. Each body byte leaves on the result
// channel tagged with the id and length; the final one has
// last_of_message set. A zero-length header yields one marker item with
// byte_valid clear, body_byte zero and last_of_message set.
// Latency: each result is registered in the output stage, in the main
// register, or first in the skid register while the main entry is held.
// Throughput: one byte per cycle while the output register has space.
// Stall: a two-entry output register absorbs one extra result; stream
// ready drops only while both entries are full and recovers as the
// receiver takes items.
// Reset (arst_n low): header collection restarts at byte zero, the id
// reads all ones and the length zero, and the output register empties.
// Depends on lpmd_pkg, lpmd_if, lpmd_tracker and lpmd_out_stage.
module length_prefixed_message_deframer (
	input  logic        clk,
	input  logic        arst_n,
	lpmd_byte_if.sink   stream,
	lpmd_msg_if.source  result
);
	import lpmd_pkg::*;

	logic      accept;
	logic      space;
	msg_push_t res;
	msg_item_t out_item;

	assign stream.ready = space;
	assign accept       = stream.valid && space;

	lpmd_tracker u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.stream_byte (stream.stream_byte),
		.res         (res)
	);

	lpmd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.space     (space),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_item  (out_item)
	);

	assign result.message_id      = out_item.message_id;
	assign result.body_length     = out_item.body_length;
	assign result.body_byte       = out_item.body_byte;
	assign result.byte_valid      = out_item.byte_valid;
	assign result.last_of_message = out_item.last_of_message;

endmodule

// ===== dv/deframer_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the length-prefixed message deframer: watches the byte and
// result channels, predicts tagged body and marker items and compares them field by field.
// Depends on lpmd_pkg and lpmd_if.
module deframer_checker (
	input  logic        clk,
	input  logic        arst_n,
	lpmd_byte_if        stream,
	lpmd_msg_if         result,
	output int          errors,
	output int          pending
);
	import lpmd_pkg::*;

	msg_item_t             expected_items[$];

	logic                  in_body;
	logic [HDR_CNT_W-1:0]  hdr_idx;
	logic [31:0]           id_word;
	logic [31:0]           len_word;
	logic [31:0]           left_count;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
		errors++;
	endtask

	// Update the header/body tracker with one byte and queue any result it causes.
	task automatic deframe_byte(input logic [7:0] b);
		msg_item_t r;
		logic      fin;
		if (in_body) begin
			fin = (left_count <= 32'd1);
			r = '{id_word, len_word, b, 1'b1, fin};
			expected_items.push_back(r);
			if (fin) begin
				left_count = '0;
				in_body    = 1'b0;
				hdr_idx    = '0;
			end else begin
				left_count = left_count - 32'd1;
			end
		end else begin
			if (hdr_idx < WORD_BYTES)
				id_word[8*hdr_idx[1:0] +: 8] = b;
			else
				len_word[8*hdr_idx[1:0] +: 8] = b;
			if (hdr_idx == HDR_LAST_CNT) begin
				hdr_idx = '0;
				if (len_word == 32'd0) begin
					// empty body: a single marker item, stay in header collection
					r = '{id_word, len_word, 8'd0, 1'b0, 1'b1};
					expected_items.push_back(r);
				end else begin
					left_count = len_word;
					in_body    = 1'b1;
				end
			end else begin
				hdr_idx = hdr_idx + 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		msg_item_t want;
		if (!arst_n) begin
			in_body    = 1'b0;
			hdr_idx    = '0;
			id_word    = ID_RESET;
			len_word   = '0;
			left_count = '0;
			expected_items.delete();
		end else begin
			// results are registered and never leave in the cycle their byte is taken, so retire before predicting
			if (result.valid && result.ready) begin
				if (expected_items.size() == 0) begin
					report_mismatch("unexpected result, message_id", result.message_id, '0);
				end else begin
					want = expected_items.pop_front();
					if (result.message_id !== want.message_id)
						report_mismatch("message_id", result.message_id, want.message_id);
					if (result.body_length !== want.body_length)
						report_mismatch("body_length", result.body_length, want.body_length);
					if (result.body_byte !== want.body_byte)
						report_mismatch("body_byte", 32'(result.body_byte),
							32'(want.body_byte));
					if (result.byte_valid !== want.byte_valid)
						report_mismatch("byte_valid", 32'(result.byte_valid),
							32'(want.byte_valid));
					if (result.last_of_message !== want.last_of_message)
						report_mismatch("last_of_message", 32'(result.last_of_message),
							32'(want.last_of_message));
				end
			end
			if (stream.valid && stream.ready)
				deframe_byte(stream.stream_byte);
		end
		pending = expected_items.size();
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the deframer testbench: clock, reset, byte stimulus and result-side
// backpressure. Depends on lpmd_pkg, lpmd_if, the deframer and deframer_checker.
module tb_top;
	import lpmd_pkg::*;

	localparam int MSG_ITEMS   = 900;
	localparam int HOLD_START  = 200;
	localparam int HOLD_CYCLES = 60;
	localparam int RX_CALM_LO  = 600;
	localparam int RX_CALM_HI  = 800;
	localparam int TX_CALM_LO  = 600;
	localparam int TX_CALM_HI  = 800;
	localparam int IDLE_PCT    = 18;

	logic clk = 1'b0;
	logic arst_n;
	int   cyc = 0;
	int   bytes_sent = 0;
	int   errors;
	int   pending;

	lpmd_byte_if stream_if();
	lpmd_msg_if  result_if();

	length_prefixed_message_deframer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.result (result_if)
	);

	deframer_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream_if),
		.result  (result_if),
		.errors  (errors),
		.pending (pending)
	);

	always #1 clk = ~clk;

	always @(posedge clk) cyc <= cyc + 1;

	initial begin
		#200000;
		$display("Some tests failed");
		$finish;
	end

	// Receiver: one long hold-off so the block fills and stalls its input,
	// a calm stretch, random stalls elsewhere.
	initial begin
		result_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
				result_if.ready <= 1'b0;
			else if (cyc >= RX_CALM_LO && cyc < RX_CALM_HI)
				result_if.ready <= 1'b1;
			else
				result_if.ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic push_byte(input logic [7:0] b);
		while (!(cyc >= TX_CALM_LO && cyc < TX_CALM_HI) && $urandom_range(99) < IDLE_PCT) begin
			stream_if.valid <= 1'b0;
			@(posedge clk);
		end
		stream_if.valid       <= 1'b1;
		stream_if.stream_byte <= b;
		do @(posedge clk); while (!stream_if.ready);
		bytes_sent++;
	endtask

	// Header is id then length, each least significant byte first.
	task automatic send_header(input logic [31:0] id, input logic [31:0] len);
		for (int k = 0; k < WORD_BYTES; k++) push_byte(id[8*k +: 8]);
		for (int k = 0; k < WORD_BYTES; k++) push_byte(len[8*k +: 8]);
	endtask

	initial begin : stimulus
		int unsigned sel;
		logic [31:0] len;
		arst_n                = 1'b0;
		stream_if.valid       <= 1'b0;
		stream_if.stream_byte <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty body with all-zero id, one-byte body with all-ones id and byte,
		// then a short body across the byte extremes
		send_header(32'h0000_0000, 32'd0);
		send_header(32'hFFFF_FFFF, 32'd1);
		push_byte(8'hFF);
		send_header(32'hA5C3_0F81, 32'd3);
		push_byte(8'h00);
		push_byte(8'h80);
		push_byte(8'h7F);

		while (bytes_sent < MSG_ITEMS) begin
			sel = $urandom_range(99);
			if (sel < 12)
				len = 32'd0;
			else if (sel < 40)
				len = $urandom_range(4, 1);
			else if (sel < 85)
				len = $urandom_range(24, 5);
			else
				len = $urandom_range(90, 25);
			send_header($urandom, len);
			for (int unsigned i = 0; i < len; i++) push_byte(8'($urandom_range(255)));
		end

		// huge length: high length bits seen on results, body never finishes
		send_header(32'h8000_0001, 32'hFFFF_FFFF);
		for (int i = 0; i < 12; i++) push_byte(8'($urandom_range(255)));
		stream_if.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
